// ----- rtl/tccw_pkg.sv -----
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = 16;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCR_PRIME,
        ST_SCR_COPY,
        ST_SCR_FILL,
        ST_CLEAR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec_put;
        logic exec_write;
        logic rd_pos;
        logic rd_copy;
        logic copy_step;
        logic fill_step;
        logic fill_rst_color;
        logic ptr_clr;
        logic home;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic need_scroll;
        logic ptr_copy_last;
        logic ptr_last;
    } stat_t;

endpackage

// ----- rtl/tccw_ctrl.sv -----
`timescale 1ns / 1ps

module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (ctrl.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.ptr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (stat.cmd)
                    CMD_PUT:   state_next = stat.need_scroll ? ST_SCR_PRIME : ST_RESP;
                    CMD_CLEAR: state_next = ST_CLEAR;
                    default:   state_next = ST_RESP;
                endcase
            end
            ST_SCR_PRIME: state_next = ST_SCR_COPY;
            ST_SCR_COPY:
            begin
                if (stat.ptr_copy_last)
                    state_next = ST_SCR_FILL;
            end
            ST_SCR_FILL,
            ST_CLEAR:
            begin
                if (stat.ptr_last)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_INIT:
            begin
                ctrl.fill_step      = 1'b1;
                ctrl.fill_rst_color = 1'b1;
            end
            ST_IDLE:
            begin
                ctrl.capture = s_tvalid;
            end
            ST_EXEC:
            begin
                case (stat.cmd)
                    CMD_PUT:
                    begin
                        ctrl.exec_put = 1'b1;
                        ctrl.ptr_clr  = 1'b1;
                    end
                    CMD_WRITE: ctrl.exec_write = 1'b1;
                    CMD_CLEAR:
                    begin
                        ctrl.home    = 1'b1;
                        ctrl.ptr_clr = 1'b1;
                    end
                    default:   ctrl.rd_pos = 1'b1;
                endcase
            end
            ST_SCR_PRIME: ctrl.rd_copy   = 1'b1;
            ST_SCR_COPY:  ctrl.copy_step = 1'b1;
            ST_SCR_FILL,
            ST_CLEAR:     ctrl.fill_step = 1'b1;
            ST_RESP:      ctrl.out_load  = out_free;
            default:      ctrl = '0;
        endcase
    end

endmodule

// ----- rtl/tccw_dp.sv -----
`timescale 1ns / 1ps

module tccw_dp
    import tccw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COLOR_W-1:0] cfg_wdata,
    input  logic [CMD_W-1:0]   in_cmd,
    input  logic [CHAR_W-1:0]  in_char,
    input  logic [COLOR_W-1:0] in_color,
    input  logic [COL_W-1:0]   in_col,
    input  logic [ROW_W-1:0]   in_row,
    input  ctrl_t              ctrl,
    output stat_t              stat,
    output logic [COL_W-1:0]   out_col,
    output logic [ROW_W-1:0]   out_row,
    output logic [ADDR_W-1:0]  out_addr,
    output logic [CELL_W-1:0]  out_data
);

    localparam int CELLS   = COLS * ROWS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int CC_W    = $clog2(COLS);
    localparam int CR_W    = $clog2(ROWS);

    logic [CELL_W-1:0]  mem [CELLS];

    cmd_t               cmd_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COLOR_W-1:0] text_color_reg;
    logic [CC_W-1:0]    cur_col_reg;
    logic [CC_W-1:0]    cur_col_next;
    logic [CR_W-1:0]    cur_row_reg;
    logic [CR_W-1:0]    cur_row_next;
    logic [CELL_AW-1:0] ptr_reg;
    logic [CELL_AW-1:0] ptr_next;
    logic [CELL_W-1:0]  rd_data_reg;

    logic               in_range;
    logic [CELL_AW-1:0] pos_addr;
    logic [CELL_AW-1:0] put_addr;
    logic [CC_W:0]      col_ext;
    logic [CC_W:0]      col_step;
    logic [CR_W:0]      row_step;
    logic [CR_W:0]      row_final;
    logic [CC_W-1:0]    put_col;
    logic [CHAR_W-1:0]  put_char;
    logic               put_we;
    logic               scroll;

    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CELL_W-1:0]  wdata;
    logic               re;
    logic [CELL_AW-1:0] raddr;
    logic [COLOR_W-1:0] fill_color;

    assign in_range = (int'(col_reg) < COLS) && (int'(row_reg) < ROWS);
    assign pos_addr = CELL_AW'(int'(row_reg) * COLS + int'(col_reg));
    assign put_addr = CELL_AW'(int'(cur_row_reg) * COLS + int'(put_col));

    // put character: cursor step and cell write
    always_comb
    begin
        col_ext   = {1'b0, cur_col_reg};
        col_step  = col_ext;
        row_step  = {1'b0, cur_row_reg};
        put_col   = cur_col_reg;
        put_char  = char_reg;
        put_we    = 1'b0;
        case (char_reg)
            CH_NEWLINE:
            begin
                col_step = '0;
                row_step = row_step + 1'b1;
            end
            CH_RETURN:
            begin
                col_step = '0;
            end
            CH_BACKSPACE:
            begin
                if (cur_col_reg != '0)
                begin
                    col_step = col_ext - 1'b1;
                    put_col  = cur_col_reg - 1'b1;
                    put_char = BLANK_CHAR;
                    put_we   = 1'b1;
                end
            end
            default:
            begin
                col_step = col_ext + 1'b1;
                put_we   = 1'b1;
            end
        endcase
        row_final = row_step;
        if (int'(col_step) >= COLS)
        begin
            col_step  = '0;
            row_final = row_step + 1'b1;
        end
        scroll = (int'(row_final) >= ROWS);
    end

    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (ctrl.home)
        begin
            cur_col_next = '0;
            cur_row_next = '0;
        end
        else if (ctrl.exec_put)
        begin
            cur_col_next = col_step[CC_W-1:0];
            cur_row_next = scroll ? CR_W'(ROWS - 1) : row_final[CR_W-1:0];
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctrl.ptr_clr)
            ptr_next = '0;
        else if (ctrl.fill_step || ctrl.copy_step)
            ptr_next = ptr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            ptr_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
                text_color_reg <= cfg_wdata;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            ptr_reg     <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= cmd_t'(in_cmd);
            char_reg  <= in_char;
            color_reg <= in_color;
            col_reg   <= in_col;
            row_reg   <= in_row;
        end
    end

    // screen store ports
    assign fill_color = ctrl.fill_rst_color ? RESET_COLOR : text_color_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = {fill_color, BLANK_CHAR};
        if (ctrl.fill_step)
        begin
            we = 1'b1;
        end
        else if (ctrl.copy_step)
        begin
            we    = 1'b1;
            wdata = rd_data_reg;
        end
        else if (ctrl.exec_put)
        begin
            we    = put_we;
            waddr = put_addr;
            wdata = {text_color_reg, put_char};
        end
        else if (ctrl.exec_write)
        begin
            we    = in_range;
            waddr = pos_addr;
            wdata = {color_reg, char_reg};
        end
    end

    assign re    = ctrl.rd_pos || ctrl.rd_copy || ctrl.copy_step;
    assign raddr = ctrl.rd_pos ? pos_addr
                 : CELL_AW'(int'(ptr_reg) + COLS + int'(ctrl.copy_step));

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_data_reg <= mem[raddr];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_col  <= COL_W'(cur_col_reg);
            out_row  <= ROW_W'(cur_row_reg);
            out_addr <= ADDR_W'(int'(cur_row_reg) * COLS + int'(cur_col_reg));
            out_data <= (cmd_reg == CMD_READ && in_range) ? rd_data_reg : '0;
        end
    end

    assign stat.cmd           = cmd_reg;
    assign stat.need_scroll   = scroll;
    assign stat.ptr_copy_last = (int'(ptr_reg) == CELLS - COLS - 1);
    assign stat.ptr_last      = (int'(ptr_reg) == CELLS - 1);

endmodule

// ----- rtl/text_console_character_writer.sv -----
`timescale 1ns / 1ps
// channel   direction  tdata (low bit up)                              tuser
// s_*       in         char_code 8, cell_color 8, col 7, row 5, pad 4  cmd 2
// m_*       out        cursor_col 7, cursor_row 5, cursor_addr 11,     -
//                      cell_data 16, pad 1
// cfg_*     in         text_color 8 on cfg_we
//
// put, write and read: EXEC, then RESP, which loads the result register once it is free
// a put that scrolls adds SCR_PRIME, SCR_COPY (row copy) and SCR_FILL (bottom row blank)
// clear screen writes one cell per cycle on the write port
// after reset the store is blanked one cell per cycle, s_tready low
// a new request is taken while a result still waits on m_tready

module text_console_character_writer
    import tccw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // char_code, cell_color, col, row
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // cursor_col, cursor_row, cursor_addr, cell_data
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata
);

    ctrl_t               ctrl;
    stat_t               stat;
    logic [COL_W-1:0]    out_col;
    logic [ROW_W-1:0]    out_row;
    logic [ADDR_W-1:0]   out_addr;
    logic [CELL_W-1:0]   out_data;

    tccw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tccw_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_color  (s_tdata[15:8]),
        .in_col    (s_tdata[22:16]),
        .in_row    (s_tdata[27:23]),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_addr  (out_addr),
        .out_data  (out_data)
    );

    assign m_tdata = {1'b0, out_data, out_addr, out_row, out_col};

endmodule

// ----- rtl/tccw_check.sv -----
`timescale 1ns / 1ps

module tccw_check
    import tccw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        cfg_we,
    input logic [7:0]  cfg_wdata
);

    // cursor column stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (int'(m_tdata[6:0]) < COLS))
        else $error("cursor column beyond line end");

    // linear cursor address agrees with row and column
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ROWS <= 32) |->
        (m_tdata[22:12] == 11'(int'(m_tdata[11:7]) * COLS + int'(m_tdata[6:0]))))
        else $error("cursor address mismatch");

    // one request in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed under stall");

endmodule

bind text_console_character_writer tccw_check #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tccw_check (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import tccw_pkg::*;

    localparam int COLS        = COLS_DEF;
    localparam int ROWS        = ROWS_DEF;
    localparam int CELLS       = COLS * ROWS;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 45;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [ADDR_W-1:0] cursor_addr;
        logic [CELL_W-1:0] cell_data;
    } cursor_report_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    // shadow of the console state
    logic [CELL_W-1:0]  screen_shadow [CELLS];
    int                 shadow_col;
    int                 shadow_row;
    logic [COLOR_W-1:0] shadow_color;

    cursor_report_t expected_reports[$];
    int             mismatch_count;
    int             stall_cycles;
    bit             idle_on;

    text_console_character_writer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 15) : 0;
    endfunction

    function automatic logic [COL_W-1:0] rand_col();
        if ($urandom_range(0, 4) == 0)
            return COL_W'($urandom_range(0, 127));
        return COL_W'($urandom_range(0, COLS - 1));
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        if ($urandom_range(0, 4) == 0)
            return ROW_W'($urandom_range(0, 31));
        return ROW_W'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic void scroll_shadow();
        for (int i = 0; i < CELLS - COLS; i++)
            screen_shadow[i] = screen_shadow[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++)
            screen_shadow[i] = {shadow_color, BLANK_CHAR};
        shadow_row = ROWS - 1;
    endfunction

    // applies one request to the shadow state and queues the cursor report
    function automatic void predict_console(input cmd_t op, input logic [7:0] ch,
                                            input logic [7:0] color,
                                            input logic [6:0] col, input logic [4:0] row);
        cursor_report_t rep;
        logic           in_range;
        logic [15:0]    data;
        in_range = (col < COLS) && (row < ROWS);
        data = '0;
        case (op)
            CMD_PUT:
            begin
                if (ch == CH_NEWLINE)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                else if (ch == CH_RETURN)
                    shadow_col = 0;
                else if (ch == CH_BACKSPACE)
                begin
                    if (shadow_col > 0)
                    begin
                        shadow_col--;
                        screen_shadow[shadow_row * COLS + shadow_col] = {shadow_color, BLANK_CHAR};
                    end
                end
                else
                begin
                    screen_shadow[shadow_row * COLS + shadow_col] = {shadow_color, ch};
                    shadow_col++;
                end
                if (shadow_col >= COLS)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= ROWS)
                    scroll_shadow();
            end
            CMD_WRITE:
            begin
                if (in_range)
                    screen_shadow[row * COLS + col] = {color, ch};
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_shadow[i] = {shadow_color, BLANK_CHAR};
                shadow_col = 0;
                shadow_row = 0;
            end
            default:
            begin
                if (in_range)
                    data = screen_shadow[row * COLS + col];
            end
        endcase
        rep.cursor_col  = shadow_col[COL_W-1:0];
        rep.cursor_row  = shadow_row[ROW_W-1:0];
        rep.cursor_addr = ADDR_W'(shadow_row * COLS + shadow_col);
        rep.cell_data   = data;
        expected_reports.push_back(rep);
    endfunction

    task automatic send_request(input cmd_t op, input logic [7:0] ch, input logic [7:0] color,
                                input logic [6:0] col, input logic [4:0] row);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, row, col, color, ch};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_console(op, ch, color, col, row);
    endtask

    task automatic send_put(input logic [7:0] ch);
        send_request(CMD_PUT, ch, COLOR_W'($urandom_range(0, 255)),
                     COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
    endtask

    task automatic send_read(input logic [6:0] col, input logic [4:0] row);
        send_request(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                     COLOR_W'($urandom_range(0, 255)), col, row);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_text_color(input logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_color = value;
    endtask

    // response side stalls
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cursor_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result with nothing expected: m_tdata %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (m_tdata[6:0] !== want.cursor_col)
                begin
                    $error("cursor_col expected %0d actual %0d", want.cursor_col, m_tdata[6:0]);
                    mismatch_count++;
                end
                if (m_tdata[11:7] !== want.cursor_row)
                begin
                    $error("cursor_row expected %0d actual %0d", want.cursor_row, m_tdata[11:7]);
                    mismatch_count++;
                end
                if (m_tdata[22:12] !== want.cursor_addr)
                begin
                    $error("cursor_addr expected %0d actual %0d", want.cursor_addr,
                           m_tdata[22:12]);
                    mismatch_count++;
                end
                if (m_tdata[38:23] !== want.cell_data)
                begin
                    $error("cell_data expected %h actual %h", want.cell_data, m_tdata[38:23]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_read(7'd0, 5'd0);
        send_read(COL_W'(COLS - 1), ROW_W'(ROWS - 1));
        send_read(7'd40, 5'd12);
        send_read(COL_W'(COLS), 5'd0);
        send_read(7'h7F, 5'h1F);
        send_read(7'd0, ROW_W'(ROWS));
    endtask

    task automatic test_control_chars();
        send_put(CH_BACKSPACE);
        send_put(8'h41);
        send_put(8'hFF);
        send_put(8'h00);
        send_put(8'h80);
        send_put(CH_BACKSPACE);
        send_read(7'd3, 5'd0);
        send_put(CH_RETURN);
        send_put(CH_NEWLINE);
    endtask

    task automatic test_cell_access();
        send_request(CMD_WRITE, 8'hFF, 8'hFF, COL_W'(COLS - 1), ROW_W'(ROWS - 1));
        send_request(CMD_WRITE, 8'h00, 8'h00, 7'd0, 5'd0);
        send_request(CMD_WRITE, 8'h55, 8'hAA, 7'h7F, 5'h1F);
        send_request(CMD_WRITE, 8'h12, 8'h34, COL_W'(COLS), 5'd0);
        send_read(COL_W'(COLS - 1), ROW_W'(ROWS - 1));
        send_read(7'd0, 5'd0);
        send_read(7'h7F, 5'h1F);
    endtask

    task automatic test_clear();
        set_text_color(8'h1E);
        send_request(CMD_CLEAR, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
        send_read(COL_W'(COLS - 1), ROW_W'(ROWS - 1));
    endtask

    task automatic test_random_traffic();
        logic [7:0] colors [PHASES];
        logic [6:0] wcol [4];
        logic [4:0] wrow [4];
        int         sent;
        int         len;
        int         kind;
        colors = '{8'h00, 8'hFF, 8'h3C, 8'hC3, 8'h00, 8'h00};
        colors[4] = COLOR_W'($urandom_range(0, 255));
        colors[5] = COLOR_W'($urandom_range(0, 255));
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_text_color(colors[ph]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2, 3:
                    begin
                        // a line of text, long enough at times to wrap
                        len = $urandom_range(1, 90);
                        for (int i = 0; i < len; i++)
                            send_put(CHAR_W'($urandom_range(0, 255)));
                        if ($urandom_range(0, 1))
                        begin
                            send_put(CH_NEWLINE);
                            sent++;
                        end
                        sent += len;
                    end
                    4, 5:
                    begin
                        len = $urandom_range(1, 28);
                        for (int i = 0; i < len; i++)
                            send_put(CH_NEWLINE);
                        sent += len;
                    end
                    6:
                    begin
                        len = $urandom_range(1, 4);
                        for (int i = 0; i < len; i++)
                        begin
                            wcol[i] = rand_col();
                            wrow[i] = rand_row();
                            send_request(CMD_WRITE, CHAR_W'($urandom_range(0, 255)),
                                         COLOR_W'($urandom_range(0, 255)), wcol[i], wrow[i]);
                        end
                        for (int i = 0; i < len; i++)
                            send_read(wcol[i], wrow[i]);
                        sent += 2 * len;
                    end
                    7:
                    begin
                        len = $urandom_range(1, 6);
                        for (int i = 0; i < len; i++)
                            send_read(rand_col(), rand_row());
                        sent += len;
                    end
                    8:
                    begin
                        len = $urandom_range(2, 12);
                        for (int i = 0; i < len; i++)
                        begin
                            case ($urandom_range(0, 3))
                                0: send_put(CH_BACKSPACE);
                                1: send_put(CH_RETURN);
                                2: send_put(CH_NEWLINE);
                                default: send_put(CHAR_W'($urandom_range(0, 255)));
                            endcase
                        end
                        send_read(COL_W'($urandom_range(0, COLS - 1)),
                                  ROW_W'($urandom_range(0, ROWS - 1)));
                        sent += len + 1;
                    end
                    default:
                    begin
                        if ($urandom_range(0, 2) == 0)
                            send_request(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                         COLOR_W'($urandom_range(0, 255)), rand_col(),
                                         rand_row());
                        else
                            send_request(cmd_t'($urandom_range(0, 3)),
                                         CHAR_W'($urandom_range(0, 255)),
                                         COLOR_W'($urandom_range(0, 255)), rand_col(),
                                         rand_row());
                        sent += 1;
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_PUT;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        mismatch_count = 0;
        stall_cycles   = 0;
        idle_on        = 1'b1;
        for (int i = 0; i < CELLS; i++)
            screen_shadow[i] = {RESET_COLOR, BLANK_CHAR};
        shadow_col   = 0;
        shadow_row   = 0;
        shadow_color = RESET_COLOR;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_control_chars();
        test_cell_access();
        test_clear();
        test_random_traffic();

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
